// ===== hdl/hsl_saturation_adjust_assert.svh =====
`ifndef HSL_SATURATION_ADJUST_ASSERT_SVH
`define HSL_SATURATION_ADJUST_ASSERT_SVH

// check a condition on the next cycle
`define HSL_SA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsl_sa next-cycle check failed");

// check a condition in the same cycle
`define HSL_SA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsl_sa same-cycle check failed");

`endif

// ===== hdl/hsl_sa_pkg.sv =====
package hsl_sa_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned SUM_W   = 9;
  localparam int unsigned QUOT_W  = 24;
  localparam int unsigned DIV_STG = 24;
  localparam int unsigned PROD_W  = 36;

  typedef struct packed {
    logic [2:0][CH_W-1:0] ch;
    logic [SUM_W-1:0]     sum;
    logic                 neg;
    logic                 gray;
  } side_t;

endpackage

// ===== hdl/hsl_sa_div.sv =====
module hsl_sa_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [hsl_sa_pkg::CH_W-1:0]         in_num_hi,
  input  logic [hsl_sa_pkg::CH_W-1:0]         in_divisor,
  input  hsl_sa_pkg::side_t                   in_side,
  output logic                                out_valid,
  output logic [hsl_sa_pkg::QUOT_W-1:0]       out_quot,
  output hsl_sa_pkg::side_t                   out_side
);

  localparam int unsigned N = hsl_sa_pkg::DIV_STG;
  localparam int unsigned W = hsl_sa_pkg::CH_W;
  localparam int unsigned Q = hsl_sa_pkg::QUOT_W;

  logic [N-1:0]      vld_r;
  logic [W-1:0]      rem_r   [N];
  logic [Q-1:0]      sh_r    [N];
  logic [W-1:0]      dv_r    [N];
  hsl_sa_pkg::side_t side_r  [N];

  logic [W-1:0]      rem_nxt [N];
  logic [Q-1:0]      sh_nxt  [N];
  logic [N-1:0]      vld_nxt;
  logic [W-1:0]      dv_nxt  [N];
  hsl_sa_pkg::side_t side_nxt[N];

  always_comb begin
    logic [W-1:0] rem_src;
    logic [Q-1:0] sh_src;
    logic [W:0]   t;
    logic         ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_src     = '0;
        sh_src      = {in_num_hi, {(Q-W){1'b0}}};
        dv_nxt[k]   = in_divisor;
        vld_nxt[k]  = in_valid;
        side_nxt[k] = in_side;
      end else begin
        rem_src     = rem_r[k-1];
        sh_src      = sh_r[k-1];
        dv_nxt[k]   = dv_r[k-1];
        vld_nxt[k]  = vld_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      t  = {rem_src, sh_src[Q-1]};
      ge = (t >= {1'b0, dv_nxt[k]});
      rem_nxt[k] = ge ? W'(t - {1'b0, dv_nxt[k]}) : t[W-1:0];
      sh_nxt[k]  = {sh_src[Q-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        sh_r[k]   <= sh_nxt[k];
        dv_r[k]   <= dv_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_quot  = sh_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ===== hdl/hsl_saturation_adjust.sv =====
// channel | dir | tdata (low bit up)                  | tuser/tlast
// in_     | in  | blue_in, green_in, red_in (8 each)  | none
// out_    | out | blue_out, green_out, red_out        | none
// cfg_    | in  | saturation_percent (8, signed)      | none
// One pixel per cycle unless the output stalls; the pipe has 3 front stages, 24 divider stages,
// a multiply stage and a clip stage. The 24-stage restoring divider sets the depth.
// rst_n clears all valid bits and sets the percent to 0.
// out_tready low with a result waiting freezes the whole pipe; in_tready follows.
`include "hsl_saturation_adjust_assert.svh"

module hsl_saturation_adjust (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue_in, green_in, red_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // blue_out, green_out, red_out
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata   // saturation_percent
);

  localparam int unsigned W = hsl_sa_pkg::CH_W;
  localparam int unsigned S = hsl_sa_pkg::SUM_W;
  localparam int unsigned Q = hsl_sa_pkg::QUOT_W;
  localparam int unsigned P = hsl_sa_pkg::PROD_W;

  logic signed [7:0] pct_r;
  logic              en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= '0;
    end else if (cfg_we) begin
      pct_r <= cfg_wdata;
    end
  end

  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // stage 1
  logic signed [7:0]    p_nxt, p1_r;
  logic [2:0][W-1:0]    ch1_r;
  logic                 v1_r;

  always_comb begin
    if (pct_r > 8'sd100) begin
      p_nxt = 8'sd100;
    end else if (pct_r < -8'sd100) begin
      p_nxt = -8'sd100;
    end else begin
      p_nxt = pct_r;
    end
  end

  // stage 2
  logic [W-1:0]         mx_nxt, mn_nxt, mx2_r, mn2_r;
  logic [2:0][W-1:0]    ch2_r;
  logic signed [7:0]    p2_r;
  logic                 v2_r;

  always_comb begin
    mx_nxt = ch1_r[0];
    mn_nxt = ch1_r[0];
    for (int i = 1; i < 3; i++) begin
      if (ch1_r[i] > mx_nxt) begin
        mx_nxt = ch1_r[i];
      end
      if (ch1_r[i] < mn_nxt) begin
        mn_nxt = ch1_r[i];
      end
    end
  end

  // stage 3
  logic [S-1:0]  sum2, den2;
  logic [W-1:0]  d2;
  logic [15:0]   lhs, rhs;
  logic [6:0]    pmag;
  logic [W-1:0]  num_nxt, dv_nxt, num3_r, dv3_r;
  hsl_sa_pkg::side_t side_nxt, side3_r;
  logic          v3_r;

  always_comb begin
    sum2 = {1'b0, mx2_r} + {1'b0, mn2_r};
    d2   = mx2_r - mn2_r;
    den2 = (sum2 < S'(255)) ? sum2 : S'(10'd510 - {1'b0, sum2});
    pmag = p2_r[6:0];
    lhs  = 16'(pmag) * 16'(den2) + 16'(d2) * 16'd100;
    rhs  = 16'(den2) * 16'd100;
    side_nxt.ch   = ch2_r;
    side_nxt.sum  = sum2;
    side_nxt.neg  = p2_r[7];
    side_nxt.gray = (d2 == '0);
    if (side_nxt.gray) begin
      num_nxt = '0;
      dv_nxt  = W'(1);
    end else if (p2_r[7]) begin
      num_nxt = W'(p2_r + 8'sd100);
      dv_nxt  = W'(100);
    end else if (lhs >= rhs) begin
      num_nxt = W'(den2 - S'(d2));
      dv_nxt  = d2;
    end else begin
      num_nxt = W'(pmag);
      dv_nxt  = W'(100) - W'(pmag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch1_r   <= in_tdata;
      p1_r    <= p_nxt;
      mx2_r   <= mx_nxt;
      mn2_r   <= mn_nxt;
      ch2_r   <= ch1_r;
      p2_r    <= p1_r;
      num3_r  <= num_nxt;
      dv3_r   <= dv_nxt;
      side3_r <= side_nxt;
    end
  end

  logic              vq;
  logic [Q-1:0]      quot;
  hsl_sa_pkg::side_t sideq;

  hsl_sa_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (v3_r),
    .in_num_hi  (num3_r),
    .in_divisor (dv3_r),
    .in_side    (side3_r),
    .out_valid  (vq),
    .out_quot   (quot),
    .out_side   (sideq)
  );

  // multiply stage
  logic signed [P-1:0] prod_nxt [3];
  logic signed [P-1:0] base_nxt [3];
  logic signed [P-1:0] prod_r   [3];
  logic signed [P-1:0] base_r   [3];
  logic [2:0][W-1:0]   chm_r;
  logic                graym_r, vm_r;

  always_comb begin
    logic signed [S+1:0] dd;
    for (int i = 0; i < 3; i++) begin
      dd = $signed({2'b00, sideq.ch[i], 1'b0}) - $signed({2'b00, sideq.sum});
      prod_nxt[i] = P'(dd * $signed({1'b0, quot}));
      if (sideq.neg) begin
        base_nxt[i] = $signed(P'({sideq.sum, 16'd0}));
      end else begin
        base_nxt[i] = $signed(P'({sideq.ch[i], 17'd0}));
      end
    end
  end

  // clip stage
  logic [2:0][W-1:0] res_nxt, res_r;
  logic              vo_r;

  always_comb begin
    logic signed [P-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t = base_r[i] + prod_r[i];
      if (graym_r) begin
        res_nxt[i] = chm_r[i];
      end else if (t <= 0) begin
        res_nxt[i] = '0;
      end else if (t[P-1:17] > (P-17)'(255)) begin
        res_nxt[i] = '1;
      end else begin
        res_nxt[i] = t[24:17];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vm_r <= vq;
      vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= prod_nxt[i];
        base_r[i] <= base_nxt[i];
      end
      chm_r   <= sideq.ch;
      graym_r <= sideq.gray;
      res_r   <= res_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = res_r;

  `HSL_SA_ASSERT_NOW(a_pct_clamped, v1_r, (p1_r <= 8'sd100 && p1_r >= -8'sd100))
  `HSL_SA_ASSERT_NEXT(a_stall_freeze, (out_tvalid && !out_tready), ($stable(vm_r) && $stable(vq)))
  `HSL_SA_ASSERT_NOW(a_gray_divisor, (v3_r && side3_r.gray), (dv3_r != '0))
  `HSL_SA_ASSERT_NOW(a_divisor_nonzero, v3_r, (dv3_r != '0))

endmodule
